// File: hdl/sss_pkg.sv
// Shared types and constants of the surrogate split search block.
`timescale 1ns / 1ps
`default_nettype none
package sss_pkg;
  localparam int MAX_OBS  = 1024;
  localparam int OBS_AW   = $clog2(MAX_OBS);
  localparam int CNT_W    = OBS_AW + 1;
  localparam int MAX_CATS = 64;
  localparam int CAT_AW   = $clog2(MAX_CATS);
  localparam int NCAT_W   = 7;
  localparam int WSUM_W   = 42;
  localparam int TOT_W    = 43;
  localparam int NUM_W    = TOT_W + 16;
  localparam int STORE_W  = 67;
  localparam int CATW_W   = 2 * WSUM_W;

  localparam logic [16:0] Q_ONE = 17'd65536;

  localparam logic [1:0] DIR_NONE  = 2'd0;
  localparam logic [1:0] DIR_LEFT  = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;

  typedef enum logic [2:0] {
    CFG_NODE_ID   = 3'd0,
    CFG_NUM_CATS  = 3'd1,
    CFG_DEN_MODE  = 3'd2,
    CFG_TOT_LEFT  = 3'd3,
    CFG_TOT_RIGHT = 3'd4
  } cfg_idx_t;

  typedef enum logic [4:0] {
    S_LOAD, S_C1_RD, S_C1_EV, S_C1_END, S_C2_RD, S_C2_EV,
    S_K1_RD, S_K1_CA, S_K1_WR, S_K2_RD, S_K2_EV, S_K2_END, S_K3_RD, S_K3_EV,
    S_PREP, S_FRAC, S_DIV1, S_DIV2, S_EMIT_C, S_E_RD, S_E_EV
  } state_t;
endpackage
`default_nettype wire

// File: hdl/sss_ram.sv
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module sss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: hdl/sss_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated at Q1.16 one.
`timescale 1ns / 1ps
`default_nettype none
module sss_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [sss_pkg::NUM_W-1:0] num,
  input  wire logic [sss_pkg::TOT_W-1:0] den,
  output logic                           done,
  output logic [16:0]                    quo
);
  import sss_pkg::*;

  localparam int ITER_W = $clog2(NUM_W + 1);

  logic                run_r, done_r, ovf_r;
  logic [ITER_W-1:0]   cnt_r;
  logic [TOT_W:0]      rem_r, rem_sh, rem_nxt;
  logic [NUM_W-1:0]    num_r;
  logic [TOT_W-1:0]    den_r;
  logic [17:0]         q_r, q_nxt;
  logic                ge;

  always_comb begin
    rem_sh  = {rem_r[TOT_W-1:0], num_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, den_r};
    rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;
    q_nxt   = {q_r[16:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
        rem_r <= '0;
        num_r <= num;
        den_r <= den;
        q_r   <= '0;
        ovf_r <= 1'b0;
      end else if (run_r) begin
        rem_r <= rem_nxt;
        num_r <= {num_r[NUM_W-2:0], 1'b0};
        q_r   <= q_nxt;
        ovf_r <= ovf_r | q_r[17];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == ITER_W'(NUM_W - 1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = (ovf_r || q_r > {1'b0, Q_ONE}) ? Q_ONE : q_r[16:0];
endmodule
`default_nettype wire

// File: hdl/surrogate_split_search_top.sv
// Top level of the surrogate split search: load, scan, divide and emit.
//
// Use: observations of one tree node arrive on the in_ ports, one beat per
// cycle, taken when start is high and busy is low. Each is written to the
// observation store (1024 entries; further beats are dropped). The beat with
// in_last_obs set starts the search and raises busy.
// Continuous mode (num_categories = 0): two scans of the store, then up to
// two divisions on the shared divider (each a start, then the bit-serial
// quotient steps), then one result beat.
// Categorical mode: one scan of the store with a read-modify-write of the
// category RAM, two passes over the categories, up to two divisions, then
// one result beat per category.
// busy falls with the final result beat.
// Results: out_valid marks each beat for exactly one cycle; the receiver
// cannot stall, so nothing waits on it.
// Configuration: cfg_we with cfg_index and cfg_data writes a register at once;
// write only while busy is low and no load is in progress.
// Reset: rst_n, synchronous, clears control state and the configuration
// registers; the stores need no clearing pass (category entries carry seen bits).
`timescale 1ns / 1ps
`default_nettype none
module surrogate_split_search_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [31:0]  in_obs_x,
  input  wire logic         in_x_missing,
  input  wire logic [15:0]  in_obs_node,
  input  wire logic [1:0]   in_obs_direction,
  input  wire logic [31:0]  in_obs_weight,
  input  wire logic         in_last_obs,
  output logic              out_valid,
  output logic [5:0]        out_cat_index,
  output logic [1:0]        out_cat_direction,
  output logic signed [31:0] out_split_point,
  output logic              out_split_found,
  output logic [16:0]       out_agreement,
  output logic signed [17:0] out_adjusted_agreement,
  output logic              out_status,
  output logic              out_last_result,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [41:0]  cfg_data
);
  import sss_pkg::*;

  // configuration
  logic [15:0]       node_id_r;
  logic [NCAT_W-1:0] num_cats_r;
  logic              den_mode_r;
  logic [WSUM_W-1:0] tot_l_r, tot_r_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r  <= '0;
      num_cats_r <= '0;
      den_mode_r <= 1'b0;
      tot_l_r    <= '0;
      tot_r_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NODE_ID:   node_id_r  <= cfg_data[15:0];
        CFG_NUM_CATS:  num_cats_r <= cfg_data[NCAT_W-1:0];
        CFG_DEN_MODE:  den_mode_r <= cfg_data[0];
        CFG_TOT_LEFT:  tot_l_r    <= cfg_data;
        CFG_TOT_RIGHT: tot_r_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [NCAT_W-1:0] ncat;
  assign ncat = (num_cats_r > NCAT_W'(MAX_CATS)) ? NCAT_W'(MAX_CATS) : num_cats_r;

  // sequencer state
  state_t state_r, state_nxt;
  logic [CNT_W-1:0]  load_cnt_r, load_cnt_nxt, idx_r, idx_nxt;
  logic [NCAT_W-1:0] cat_r, cat_nxt;
  logic              first_r, first_nxt;
  logic [CNT_W-1:0]  c_ll_r, c_lr_r, c_rl_r, c_rr_r;
  logic [CNT_W-1:0]  c_ll_nxt, c_lr_nxt, c_rl_nxt, c_rr_nxt;
  logic [WSUM_W-1:0] w_ll_r, w_lr_r, w_rl_r, w_rr_r;
  logic [WSUM_W-1:0] w_ll_nxt, w_lr_nxt, w_rl_nxt, w_rr_nxt;
  logic [WSUM_W-1:0] agree_r, agree_nxt;
  logic [31:0]       cut_r, cut_nxt, prev_x_r, prev_x_nxt;
  logic [1:0]        side_r, side_nxt;
  logic              found_r, found_nxt;
  logic [TOT_W-1:0]  loc_tot_r, loc_tot_nxt, total_r, total_nxt;
  logic [TOT_W-1:0]  loc_maj_r, loc_maj_nxt, maj_r, maj_nxt, den2_r, den2_nxt;
  logic [MAX_CATS-1:0] seen_r, seen_nxt;
  logic [CAT_AW-1:0] k_cat_r, k_cat_nxt;
  logic [31:0]       k_w_r, k_w_nxt;
  logic [1:0]        k_dir_r, k_dir_nxt;
  logic [WSUM_W-1:0] sum_l_r, sum_l_nxt, sum_r_r, sum_r_nxt;
  logic              def_right_r, def_right_nxt;
  logic              neg_r, neg_nxt, st_r, st_nxt;
  logic [16:0]       agr_r, agr_nxt;
  logic [17:0]       adj_r, adj_nxt;

  // result beat
  logic              o_valid_nxt, o_valid_r;
  logic [5:0]        o_idx_nxt, o_idx_r;
  logic [1:0]        o_dir_nxt, o_dir_r;
  logic [31:0]       o_cut_nxt, o_cut_r;
  logic              o_found_nxt, o_found_r, o_last_nxt, o_last_r;
  logic [16:0]       o_agr_nxt, o_agr_r;
  logic [17:0]       o_adj_nxt, o_adj_r;
  logic              o_st_nxt, o_st_r;

  // stores
  logic                st_we;
  logic [STORE_W-1:0]  st_wdata, st_rdata;
  logic [OBS_AW-1:0]   st_raddr;
  logic [31:0]         s_x, s_w;
  logic [1:0]          s_dir;
  logic                s_mem;
  logic                cat_we;
  logic [CAT_AW-1:0]   cat_waddr, cat_raddr;
  logic [CATW_W-1:0]   cat_wdata, cat_rdata;
  logic [WSUM_W-1:0]   e_l, e_r;

  // shared divider
  logic              div_start, div_done;
  logic [NUM_W-1:0]  div_num;
  logic [TOT_W-1:0]  div_den;
  logic [16:0]       div_quo;

  assign s_x   = st_rdata[31:0];
  assign s_w   = st_rdata[63:32];
  assign s_dir = st_rdata[65:64];
  assign s_mem = st_rdata[66];

  sss_ram #(.WIDTH(STORE_W), .DEPTH(MAX_OBS)) u_obs_ram (
    .clk, .we(st_we), .waddr(load_cnt_r[OBS_AW-1:0]), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  sss_ram #(.WIDTH(CATW_W), .DEPTH(MAX_CATS)) u_cat_ram (
    .clk, .we(cat_we), .waddr(cat_waddr), .wdata(cat_wdata),
    .raddr(cat_raddr), .rdata(cat_rdata)
  );

  sss_div u_div (
    .clk, .rst_n, .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  // unseen category entries read as zero
  logic [CAT_AW-1:0] cur_cat;
  assign cur_cat = (state_r == S_K1_WR) ? k_cat_r : cat_r[CAT_AW-1:0];
  assign e_l = seen_r[cur_cat] ? cat_rdata[WSUM_W-1:0] : '0;
  assign e_r = seen_r[cur_cat] ? cat_rdata[CATW_W-1:WSUM_W] : '0;

  logic [CNT_W:0]    lsum_cnt, rsum_cnt;
  logic [WSUM_W-1:0] a_cand, b_cand;
  logic [32:0]       mid_sum;
  logic              code_ok;
  logic signed [31:0] code_s;

  assign lsum_cnt = {1'b0, c_ll_r} + {1'b0, c_rl_r};
  assign rsum_cnt = {1'b0, c_lr_r} + {1'b0, c_rr_r};
  assign a_cand   = w_ll_r + w_rr_r;
  assign b_cand   = w_lr_r + w_rl_r;
  assign mid_sum  = {s_x[31], s_x} + {prev_x_r[31], prev_x_r};
  assign code_s   = s_x;
  assign code_ok  = s_mem && (code_s >= 32'sd1) && (code_s <= $signed({25'd0, ncat}));

  always_comb begin
    state_nxt = state_r;
    load_cnt_nxt = load_cnt_r; idx_nxt = idx_r; cat_nxt = cat_r; first_nxt = first_r;
    c_ll_nxt = c_ll_r; c_lr_nxt = c_lr_r; c_rl_nxt = c_rl_r; c_rr_nxt = c_rr_r;
    w_ll_nxt = w_ll_r; w_lr_nxt = w_lr_r; w_rl_nxt = w_rl_r; w_rr_nxt = w_rr_r;
    agree_nxt = agree_r; cut_nxt = cut_r; prev_x_nxt = prev_x_r; side_nxt = side_r;
    found_nxt = found_r; loc_tot_nxt = loc_tot_r; loc_maj_nxt = loc_maj_r;
    total_nxt = total_r; maj_nxt = maj_r; den2_nxt = den2_r; seen_nxt = seen_r;
    k_cat_nxt = k_cat_r; k_w_nxt = k_w_r; k_dir_nxt = k_dir_r;
    sum_l_nxt = sum_l_r; sum_r_nxt = sum_r_r; def_right_nxt = def_right_r;
    neg_nxt = neg_r; st_nxt = st_r; agr_nxt = agr_r; adj_nxt = adj_r;
    o_valid_nxt = 1'b0; o_idx_nxt = o_idx_r; o_dir_nxt = o_dir_r; o_cut_nxt = o_cut_r;
    o_found_nxt = o_found_r; o_last_nxt = o_last_r; o_agr_nxt = o_agr_r;
    o_adj_nxt = o_adj_r; o_st_nxt = o_st_r;
    st_we = 1'b0;
    st_wdata = {(in_obs_node == node_id_r) && !in_x_missing, in_obs_direction,
                in_obs_weight, in_obs_x};
    st_raddr = idx_r[OBS_AW-1:0];
    cat_we = 1'b0; cat_waddr = k_cat_r;
    cat_wdata = {e_r, e_l};
    cat_raddr = cat_r[CAT_AW-1:0];
    div_start = 1'b0; div_num = '0; div_den = total_r;

    case (state_r)
      S_LOAD: begin
        if (start) begin
          if (load_cnt_r < CNT_W'(MAX_OBS)) begin
            st_we = 1'b1;
            load_cnt_nxt = load_cnt_r + 1'b1;
          end
          if (in_last_obs) begin
            idx_nxt = '0; first_nxt = 1'b1;
            c_ll_nxt = '0; c_lr_nxt = '0; c_rl_nxt = '0; c_rr_nxt = '0;
            w_ll_nxt = '0; w_lr_nxt = '0; w_rl_nxt = '0; w_rr_nxt = '0;
            cut_nxt = '0; side_nxt = DIR_NONE; prev_x_nxt = '0; found_nxt = 1'b0;
            seen_nxt = '0; sum_l_nxt = '0; sum_r_nxt = '0;
            state_nxt = (num_cats_r == '0) ? S_C1_RD : S_K1_RD;
          end
        end
      end
      // continuous, first scan: everything starts below the cut
      S_C1_RD: state_nxt = (idx_r == load_cnt_r) ? S_C1_END : S_C1_EV;
      S_C1_EV: begin
        if (s_mem) begin
          if (first_r) begin
            prev_x_nxt = s_x; first_nxt = 1'b0;
          end
          if (s_dir == DIR_LEFT) begin
            c_ll_nxt = c_ll_r + 1'b1; w_ll_nxt = w_ll_r + WSUM_W'(s_w);
          end else if (s_dir == DIR_RIGHT) begin
            c_rl_nxt = c_rl_r + 1'b1; w_rl_nxt = w_rl_r + WSUM_W'(s_w);
          end
        end
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_C1_RD;
      end
      S_C1_END: begin
        agree_nxt   = (w_ll_r > w_rl_r) ? w_ll_r : w_rl_r;
        loc_maj_nxt = TOT_W'(agree_nxt);
        loc_tot_nxt = TOT_W'(w_ll_r) + TOT_W'(w_rl_r);
        idx_nxt = '0;
        state_nxt = S_C2_RD;
      end
      // continuous, second scan: move the cut up one observation a step
      S_C2_RD: begin
        if (idx_r == load_cnt_r || lsum_cnt < (CNT_W+1)'(2)) begin
          state_nxt = S_PREP;
        end else begin
          state_nxt = S_C2_EV;
        end
      end
      S_C2_EV: begin
        if (s_mem) begin
          if (rsum_cnt >= (CNT_W+1)'(2) && s_x != prev_x_r) begin
            if (a_cand > agree_r) begin
              agree_nxt = a_cand; side_nxt = DIR_RIGHT;
              cut_nxt = mid_sum[32:1]; found_nxt = 1'b1;
            end else if (b_cand > agree_r) begin
              agree_nxt = b_cand; side_nxt = DIR_LEFT;
              cut_nxt = mid_sum[32:1]; found_nxt = 1'b1;
            end
          end
          if (s_dir == DIR_LEFT) begin
            c_ll_nxt = c_ll_r - 1'b1; c_lr_nxt = c_lr_r + 1'b1;
            w_ll_nxt = w_ll_r - WSUM_W'(s_w); w_lr_nxt = w_lr_r + WSUM_W'(s_w);
          end else if (s_dir == DIR_RIGHT) begin
            c_rl_nxt = c_rl_r - 1'b1; c_rr_nxt = c_rr_r + 1'b1;
            w_rl_nxt = w_rl_r - WSUM_W'(s_w); w_rr_nxt = w_rr_r + WSUM_W'(s_w);
          end
          prev_x_nxt = s_x;
        end
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_C2_RD;
      end
      // categorical: accumulate per-category weights, read-modify-write
      S_K1_RD: begin
        if (idx_r == load_cnt_r) begin
          cat_nxt = '0; state_nxt = S_K2_RD;
        end else begin
          state_nxt = S_K1_CA;
        end
      end
      S_K1_CA: begin
        cat_raddr = s_x[CAT_AW-1:0] - 1'b1;
        if (code_ok && (s_dir == DIR_LEFT || s_dir == DIR_RIGHT)) begin
          k_cat_nxt = cat_raddr; k_w_nxt = s_w; k_dir_nxt = s_dir;
          state_nxt = S_K1_WR;
        end else begin
          idx_nxt = idx_r + 1'b1; state_nxt = S_K1_RD;
        end
      end
      S_K1_WR: begin
        cat_we = 1'b1;
        if (k_dir_r == DIR_LEFT) begin
          cat_wdata = {e_r, e_l + WSUM_W'(k_w_r)};
        end else begin
          cat_wdata = {e_r + WSUM_W'(k_w_r), e_l};
        end
        seen_nxt[k_cat_r] = 1'b1;
        idx_nxt = idx_r + 1'b1; state_nxt = S_K1_RD;
      end
      S_K2_RD: state_nxt = (cat_r == ncat) ? S_K2_END : S_K2_EV;
      S_K2_EV: begin
        sum_l_nxt = sum_l_r + e_l; sum_r_nxt = sum_r_r + e_r;
        cat_nxt = cat_r + 1'b1; state_nxt = S_K2_RD;
      end
      S_K2_END: begin
        def_right_nxt = !(sum_l_r > sum_r_r);
        loc_maj_nxt = TOT_W'(def_right_nxt ? sum_r_r : sum_l_r);
        loc_tot_nxt = TOT_W'(sum_l_r) + TOT_W'(sum_r_r);
        agree_nxt = '0; cat_nxt = '0;
        state_nxt = S_K3_RD;
      end
      S_K3_RD: begin
        if (cat_r == ncat) begin
          found_nxt = TOT_W'(agree_r) > loc_maj_r;
          state_nxt = S_PREP;
        end else begin
          state_nxt = S_K3_EV;
        end
      end
      S_K3_EV: begin
        if (seen_r[cat_r[CAT_AW-1:0]]) begin
          if (e_l < e_r || (e_l == e_r && def_right_r)) agree_nxt = agree_r + e_r;
          else agree_nxt = agree_r + e_l;
        end
        cat_nxt = cat_r + 1'b1; state_nxt = S_K3_RD;
      end
      // fractions
      S_PREP: begin
        if (den_mode_r) begin
          total_nxt = loc_tot_r; maj_nxt = loc_maj_r;
        end else begin
          total_nxt = TOT_W'(tot_l_r) + TOT_W'(tot_r_r);
          maj_nxt = TOT_W'((tot_l_r > tot_r_r) ? tot_l_r : tot_r_r);
        end
        state_nxt = S_FRAC;
      end
      S_FRAC: begin
        den2_nxt = total_r - maj_r;
        if (total_r == '0) begin
          st_nxt = 1'b1; agr_nxt = '0; adj_nxt = '0;
          state_nxt = (num_cats_r == '0) ? S_EMIT_C : S_E_RD;
          cat_nxt = '0;
        end else begin
          div_start = 1'b1;
          div_num = {1'b0, agree_r, 16'd0};
          div_den = total_r;
          state_nxt = S_DIV1;
        end
      end
      S_DIV1: begin
        if (div_done) begin
          agr_nxt = div_quo;
          if (den2_r == '0) begin
            st_nxt = 1'b1; adj_nxt = '0;
            state_nxt = (num_cats_r == '0) ? S_EMIT_C : S_E_RD;
            cat_nxt = '0;
          end else begin
            st_nxt = 1'b0;
            neg_nxt = TOT_W'(agree_r) < maj_r;
            div_start = 1'b1;
            div_num = neg_nxt ? {maj_r - TOT_W'(agree_r), 16'd0}
                              : {TOT_W'(agree_r) - maj_r, 16'd0};
            div_den = den2_r;
            state_nxt = S_DIV2;
          end
        end
      end
      S_DIV2: begin
        if (div_done) begin
          adj_nxt = neg_r ? 18'd0 - {1'b0, div_quo} : {1'b0, div_quo};
          state_nxt = (num_cats_r == '0) ? S_EMIT_C : S_E_RD;
          cat_nxt = '0;
        end
      end
      S_EMIT_C: begin
        o_valid_nxt = 1'b1; o_idx_nxt = '0; o_dir_nxt = side_r; o_cut_nxt = cut_r;
        o_found_nxt = found_r; o_agr_nxt = agr_r; o_adj_nxt = adj_r;
        o_st_nxt = st_r; o_last_nxt = 1'b1;
        load_cnt_nxt = '0;
        state_nxt = S_LOAD;
      end
      S_E_RD: state_nxt = S_E_EV;
      S_E_EV: begin
        o_valid_nxt = 1'b1; o_idx_nxt = cat_r[CAT_AW-1:0]; o_cut_nxt = '0;
        if (!seen_r[cat_r[CAT_AW-1:0]]) o_dir_nxt = DIR_NONE;
        else if (e_l < e_r || (e_l == e_r && def_right_r)) o_dir_nxt = DIR_RIGHT;
        else o_dir_nxt = DIR_LEFT;
        o_found_nxt = found_r; o_agr_nxt = agr_r; o_adj_nxt = adj_r; o_st_nxt = st_r;
        o_last_nxt = (cat_r + 1'b1 == ncat);
        cat_nxt = cat_r + 1'b1;
        if (o_last_nxt) begin
          load_cnt_nxt = '0; state_nxt = S_LOAD;
        end else begin
          state_nxt = S_E_RD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      load_cnt_r <= '0;
      o_valid_r  <= 1'b0;
      seen_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      load_cnt_r <= load_cnt_nxt;
      o_valid_r  <= o_valid_nxt;
      seen_r     <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt; cat_r <= cat_nxt; first_r <= first_nxt;
    c_ll_r <= c_ll_nxt; c_lr_r <= c_lr_nxt; c_rl_r <= c_rl_nxt; c_rr_r <= c_rr_nxt;
    w_ll_r <= w_ll_nxt; w_lr_r <= w_lr_nxt; w_rl_r <= w_rl_nxt; w_rr_r <= w_rr_nxt;
    agree_r <= agree_nxt; cut_r <= cut_nxt; prev_x_r <= prev_x_nxt; side_r <= side_nxt;
    found_r <= found_nxt; loc_tot_r <= loc_tot_nxt; loc_maj_r <= loc_maj_nxt;
    total_r <= total_nxt; maj_r <= maj_nxt; den2_r <= den2_nxt;
    k_cat_r <= k_cat_nxt; k_w_r <= k_w_nxt; k_dir_r <= k_dir_nxt;
    sum_l_r <= sum_l_nxt; sum_r_r <= sum_r_nxt; def_right_r <= def_right_nxt;
    neg_r <= neg_nxt; st_r <= st_nxt; agr_r <= agr_nxt; adj_r <= adj_nxt;
    o_idx_r <= o_idx_nxt; o_dir_r <= o_dir_nxt; o_cut_r <= o_cut_nxt;
    o_found_r <= o_found_nxt; o_last_r <= o_last_nxt; o_agr_r <= o_agr_nxt;
    o_adj_r <= o_adj_nxt; o_st_r <= o_st_nxt;
  end

  assign busy                   = (state_r != S_LOAD);
  assign out_valid              = o_valid_r;
  assign out_cat_index          = o_idx_r;
  assign out_cat_direction      = o_dir_r;
  assign out_split_point        = o_cut_r;
  assign out_split_found        = o_found_r;
  assign out_agreement          = o_agr_r;
  assign out_adjusted_agreement = o_adj_r;
  assign out_status             = o_st_r;
  assign out_last_result        = o_last_r;
endmodule
`default_nettype wire

// File: hdl/sss_checker.sv
// Port-level checks of the surrogate split search, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module sss_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        busy,
  input wire logic        out_valid,
  input wire logic        out_last_result,
  input wire logic        out_status,
  input wire logic [17:0] out_adjusted_agreement,
  input wire logic [16:0] out_agreement
);
  a_res_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result beat without a search");
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_result |-> !busy) else $error("busy after final beat");
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_result |-> busy) else $error("run ended early");
  a_status_adj: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_adjusted_agreement == 18'd0)
    else $error("adjusted agreement set on zero denominator");
  a_agr_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_agreement <= 17'd65536) else $error("agreement above one");
endmodule

bind surrogate_split_search_top sss_checker u_sss_checker (
  .clk, .rst_n, .busy, .out_valid, .out_last_result, .out_status,
  .out_adjusted_agreement, .out_agreement
);
`default_nettype wire
